@@ rtl/mftf_pkg.sv @@
// Shared widths, register codes and constants of the magnetometer frame converter.
package mftf_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int FRAME_WORDS = (FRAME_BYTES - 1) / 2;
  localparam int WORD_IDX_W  = $clog2(FRAME_WORDS);
  localparam int COUNT_W     = 4;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int TEMP_W      = 21;
  localparam int FIELD_W     = 22;
  localparam int TOFS_W      = 11;
  localparam int FACT_W      = 10;

  // magnitude of the working value, multiplier input and product widths
  localparam int MAG_W       = 31;
  localparam int MUL_A_W     = 18;
  localparam int PROD_W      = 28;
  localparam int DIV_CNT_W   = $clog2(MAG_W);

  localparam logic [WORD_W-1:0] HALF_SCALE_OFS    = 16'h8000;
  localparam logic [WORD_W-1:0] QUARTER_SCALE_OFS = 16'h4000;
  localparam logic [FACT_W-1:0] GAIN_DIV          = 10'd100;
  localparam logic [FACT_W-1:0] OUT_DIV           = 10'd1000;
  localparam logic [FACT_W-1:0] TEMP_MUL          = 10'd1000;

  localparam logic [1:0] RES_MODE_HALF    = 2'd2;
  localparam logic [1:0] RES_MODE_QUARTER = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN,
    CFG_RES_MODE,
    CFG_XY_SENS,
    CFG_Z_SENS,
    CFG_TEMP_OFS,
    CFG_TEMP_SCALE,
    CFG_TEMP_REF,
    CFG_ERR_MASK
  } cfg_reg_t;

  localparam logic [2:0]        GAIN_RST       = 3'd7;
  localparam logic [1:0]        RES_MODE_RST   = 2'd0;
  localparam logic [FACT_W-1:0] XY_SENS_RST    = 10'd150;
  localparam logic [FACT_W-1:0] Z_SENS_RST     = 10'd242;
  localparam logic [TOFS_W-1:0] TEMP_OFS_RST   = 11'd250;
  localparam logic [FACT_W-1:0] TEMP_SCALE_RST = 10'd452;
  localparam logic [WORD_W-1:0] TEMP_REF_RST   = 16'd0;
  localparam logic [BYTE_W-1:0] ERR_MASK_RST   = 8'd16;

  function automatic logic [FACT_W-1:0] gain_factor(input logic [2:0] code);
    logic [FACT_W-1:0] f;
    case (code)
      3'd0:    f = 10'd500;
      3'd1:    f = 10'd400;
      3'd2:    f = 10'd300;
      3'd3:    f = 10'd250;
      3'd4:    f = 10'd200;
      3'd5:    f = 10'd167;
      3'd6:    f = 10'd133;
      default: f = 10'd100;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/mftf_if.sv @@
// Valid/ready channels of the magnetometer frame converter: byte input, result, register write.
interface mftf_in_if import mftf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface mftf_out_if import mftf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      read_error;
  logic [BYTE_W-1:0]         status_value;
  logic signed [TEMP_W-1:0]  temperature;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;
  logic signed [FIELD_W-1:0] field_z;

  modport source (output valid, output read_error, output status_value, output temperature,
                  output field_x, output field_y, output field_z, input ready);
  modport sink (input valid, input read_error, input status_value, input temperature,
                input field_x, input field_y, input field_z, output ready);
endinterface

interface mftf_cfg_if import mftf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/magnetometer_frame_to_field.sv @@
// Magnetometer frame converter: nine-byte response in, one temperature/field transaction out.
// Bytes other than the last of a frame are accepted back to back. The last byte starts a sequencer
// that runs one shared 18x10 multiplier and one shared radix-2 divider (31 quotient bits a division)
// over temperature and the three axes; the result is valid once the sequencer is done, or in the
// cycle after that byte for an error frame. Input is held off until the result is taken.
// Reset (rst_n low, synchronous) closes any open frame and loads the register defaults.
module magnetometer_frame_to_field import mftf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mftf_in_if.sink   in_chan,
  mftf_out_if.source out_chan,
  mftf_cfg_if.sink  cfg_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CH_TEMP,
    CH_X,
    CH_Y,
    CH_Z
  } chan_t;

  state_t state_r;
  chan_t  chan_r;
  logic   second_r;

  logic [COUNT_W-1:0] byte_count_r;
  logic [BYTE_W-1:0]  status_r;
  logic [WORD_W-1:0]  frame_mem [FRAME_WORDS];
  logic [WORD_W-1:0]  word_q_r;

  logic                 sign_r;
  logic [MAG_W-1:0]     mag_r;
  logic [FACT_W-1:0]    divisor_r;
  logic [FACT_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [2:0]        gain_r;
  logic [1:0]        res_mode_r;
  logic [FACT_W-1:0] xy_sens_r;
  logic [FACT_W-1:0] z_sens_r;
  logic [TOFS_W-1:0] temp_ofs_r;
  logic [FACT_W-1:0] temp_scale_r;
  logic [WORD_W-1:0] temp_ref_r;
  logic [BYTE_W-1:0] err_mask_r;

  logic                      read_error_r;
  logic [BYTE_W-1:0]         status_value_r;
  logic signed [TEMP_W-1:0]  temperature_r;
  logic signed [FIELD_W-1:0] field_x_r;
  logic signed [FIELD_W-1:0] field_y_r;
  logic signed [FIELD_W-1:0] field_z_r;

  logic                  in_fire;
  logic                  last_byte;
  logic [COUNT_W-1:0]    wr_pos;
  logic [WORD_IDX_W-1:0] wr_idx;
  logic [WORD_W-1:0]     axis_word;
  logic [WORD_W:0]       axis_ext;
  logic [WORD_W:0]       axis_mag;
  logic [WORD_W:0]       temp_diff;
  logic [WORD_W:0]       temp_mag;
  logic [FACT_W-1:0]     mul_fact;
  logic [PROD_W-1:0]     prod;
  logic [1:0]            mul_shift;
  logic [MAG_W-1:0]      mul_res;
  logic [FACT_W-1:0]     div_sel;
  logic [FACT_W:0]       rem_sh;
  logic                  q_bit;
  logic [FACT_W-1:0]     rem_next;
  logic [MAG_W:0]        val;
  logic [MAG_W:0]        temp_sum;

  assign in_fire        = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign last_byte = (byte_count_r == COUNT_W'(FRAME_BYTES - 1));
  assign wr_pos    = byte_count_r - COUNT_W'(1);
  assign wr_idx    = wr_pos[WORD_IDX_W:1];

  always_comb begin
    case (res_mode_r)
      RES_MODE_HALF:    axis_word = word_q_r - HALF_SCALE_OFS;
      RES_MODE_QUARTER: axis_word = word_q_r - QUARTER_SCALE_OFS;
      default:          axis_word = word_q_r;
    endcase
  end

  assign axis_ext  = {axis_word[WORD_W-1], axis_word};
  assign axis_mag  = axis_ext[WORD_W] ? (WORD_W+1)'(0) - axis_ext : axis_ext;
  assign temp_diff = {1'b0, word_q_r} - {1'b0, temp_ref_r};
  assign temp_mag  = temp_diff[WORD_W] ? (WORD_W+1)'(0) - temp_diff : temp_diff;

  // multiplier operand: 1000 for temperature, gain first and sensitivity second for an axis
  always_comb begin
    if (chan_r == CH_TEMP) begin
      mul_fact = TEMP_MUL;
    end else if (!second_r) begin
      mul_fact = gain_factor(gain_r);
    end else if (chan_r == CH_Z) begin
      mul_fact = z_sens_r;
    end else begin
      mul_fact = xy_sens_r;
    end
  end

  assign prod      = PROD_W'(mag_r[MUL_A_W-1:0]) * PROD_W'(mul_fact);
  assign mul_shift = (chan_r != CH_TEMP && second_r) ? res_mode_r : 2'd0;
  assign mul_res   = MAG_W'(prod) << mul_shift;

  always_comb begin
    if (chan_r == CH_TEMP) begin
      div_sel = (temp_scale_r == '0) ? FACT_W'(1) : temp_scale_r;
    end else if (!second_r) begin
      div_sel = GAIN_DIV;
    end else begin
      div_sel = OUT_DIV;
    end
  end

  // one quotient bit per cycle; the remainder always stays below the divisor
  assign rem_sh   = {rem_r, mag_r[MAG_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, divisor_r});
  assign rem_next = q_bit ? FACT_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[FACT_W-1:0];

  assign val      = sign_r ? (MAG_W+1)'(0) - {1'b0, mag_r} : {1'b0, mag_r};
  assign temp_sum = {{(MAG_W+1-TOFS_W){temp_ofs_r[TOFS_W-1]}}, temp_ofs_r} + val;

  always_ff @(posedge clk) begin
    if (in_fire && !in_chan.frame_start && byte_count_r != '0) begin
      if (!wr_pos[0]) begin
        frame_mem[wr_idx][WORD_W-1:BYTE_W] <= in_chan.data_byte;
      end else begin
        frame_mem[wr_idx][BYTE_W-1:0] <= in_chan.data_byte;
      end
    end
    word_q_r <= frame_mem[chan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chan_r       <= CH_TEMP;
      second_r     <= 1'b0;
      byte_count_r <= '0;
      gain_r       <= GAIN_RST;
      res_mode_r   <= RES_MODE_RST;
      xy_sens_r    <= XY_SENS_RST;
      z_sens_r     <= Z_SENS_RST;
      temp_ofs_r   <= TEMP_OFS_RST;
      temp_scale_r <= TEMP_SCALE_RST;
      temp_ref_r   <= TEMP_REF_RST;
      err_mask_r   <= ERR_MASK_RST;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_reg_t'(cfg_chan.index))
          CFG_GAIN:       gain_r       <= cfg_chan.data[2:0];
          CFG_RES_MODE:   res_mode_r   <= cfg_chan.data[1:0];
          CFG_XY_SENS:    xy_sens_r    <= cfg_chan.data[FACT_W-1:0];
          CFG_Z_SENS:     z_sens_r     <= cfg_chan.data[FACT_W-1:0];
          CFG_TEMP_OFS:   temp_ofs_r   <= cfg_chan.data[TOFS_W-1:0];
          CFG_TEMP_SCALE: temp_scale_r <= cfg_chan.data[FACT_W-1:0];
          CFG_TEMP_REF:   temp_ref_r   <= cfg_chan.data[WORD_W-1:0];
          CFG_ERR_MASK:   err_mask_r   <= cfg_chan.data[BYTE_W-1:0];
          default:        ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_chan.frame_start) begin
              status_r     <= in_chan.data_byte;
              byte_count_r <= COUNT_W'(1);
            end else if (byte_count_r == '0) begin
              // drop: no frame open
            end else if (!last_byte) begin
              byte_count_r <= byte_count_r + COUNT_W'(1);
            end else begin
              byte_count_r   <= '0;
              status_value_r <= status_r;
              if ((status_r & err_mask_r) != '0) begin
                read_error_r  <= 1'b1;
                temperature_r <= '0;
                field_x_r     <= '0;
                field_y_r     <= '0;
                field_z_r     <= '0;
                state_r       <= ST_OUT;
              end else begin
                read_error_r <= 1'b0;
                chan_r       <= CH_TEMP;
                second_r     <= 1'b0;
                state_r      <= ST_READ;
              end
            end
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (chan_r == CH_TEMP) begin
            sign_r <= temp_diff[WORD_W];
            mag_r  <= MAG_W'(temp_mag);
          end else begin
            sign_r <= axis_ext[WORD_W];
            mag_r  <= MAG_W'(axis_mag);
          end
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          mag_r     <= mul_res;
          divisor_r <= div_sel;
          rem_r     <= '0;
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          rem_r     <= rem_next;
          mag_r     <= {mag_r[MAG_W-2:0], q_bit};
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(MAG_W - 1)) begin
            if (chan_r != CH_TEMP && !second_r) begin
              second_r <= 1'b1;
              state_r  <= ST_MUL;
            end else begin
              state_r <= ST_STORE;
            end
          end
        end
        ST_STORE: begin
          case (chan_r)
            CH_TEMP: temperature_r <= signed'(temp_sum[TEMP_W-1:0]);
            CH_X:    field_x_r     <= signed'(val[FIELD_W-1:0]);
            CH_Y:    field_y_r     <= signed'(val[FIELD_W-1:0]);
            default: field_z_r     <= signed'(val[FIELD_W-1:0]);
          endcase
          if (chan_r == CH_Z) begin
            state_r <= ST_OUT;
          end else begin
            chan_r   <= chan_t'(chan_r + 2'd1);
            second_r <= 1'b0;
            state_r  <= ST_READ;
          end
        end
        ST_OUT: begin
          // hold the transaction until the sink takes it
          if (out_chan.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid        = (state_r == ST_OUT);
  assign out_chan.read_error   = read_error_r;
  assign out_chan.status_value = status_value_r;
  assign out_chan.temperature  = temperature_r;
  assign out_chan.field_x      = field_x_r;
  assign out_chan.field_y      = field_y_r;
  assign out_chan.field_z      = field_z_r;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the magnetometer frame converter: byte frames in, field readings out.
module testbench;
  import mftf_pkg::*;

  localparam int     SETTLE_CYCLES = 300;
  localparam int     HOLD_CYCLES   = 2000;
  localparam int     TIMEOUT       = 4000000;
  localparam longint GAIN_DIVISOR  = 100;
  localparam longint FIELD_DIVISOR = 1000;
  localparam longint TEMP_FACTOR   = 1000;

  typedef struct {
    logic               read_error;
    logic [BYTE_W-1:0]  status;
    logic [TEMP_W-1:0]  temp;
    logic [FIELD_W-1:0] fx;
    logic [FIELD_W-1:0] fy;
    logic [FIELD_W-1:0] fz;
  } reading_t;

  class field_scoreboard;
    logic [2:0]        gain;
    logic [1:0]        res_mode;
    logic [FACT_W-1:0] xy_sens;
    logic [FACT_W-1:0] z_sens;
    logic [TOFS_W-1:0] temp_ofs;
    logic [FACT_W-1:0] temp_scale;
    logic [WORD_W-1:0] temp_ref;
    logic [BYTE_W-1:0] err_mask;
    int unsigned       frame_len;
    logic [BYTE_W-1:0] frame [FRAME_BYTES-1];
    reading_t          readings_due[$];
    int                failures;
    int                checked;
    int                flagged;

    function new();
      gain       = GAIN_RST;
      res_mode   = RES_MODE_RST;
      xy_sens    = XY_SENS_RST;
      z_sens     = Z_SENS_RST;
      temp_ofs   = TEMP_OFS_RST;
      temp_scale = TEMP_SCALE_RST;
      temp_ref   = TEMP_REF_RST;
      err_mask   = ERR_MASK_RST;
      frame_len  = 0;
      failures   = 0;
      checked    = 0;
      flagged    = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN:       gain       = data[2:0];
        CFG_RES_MODE:   res_mode   = data[1:0];
        CFG_XY_SENS:    xy_sens    = data[FACT_W-1:0];
        CFG_Z_SENS:     z_sens     = data[FACT_W-1:0];
        CFG_TEMP_OFS:   temp_ofs   = data[TOFS_W-1:0];
        CFG_TEMP_SCALE: temp_scale = data[FACT_W-1:0];
        CFG_TEMP_REF:   temp_ref   = data[WORD_W-1:0];
        CFG_ERR_MASK:   err_mask   = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    function longint gain_of(logic [2:0] code);
      case (code)
        3'd0:    return 500;
        3'd1:    return 400;
        3'd2:    return 300;
        3'd3:    return 250;
        3'd4:    return 200;
        3'd5:    return 167;
        3'd6:    return 133;
        default: return 100;
      endcase
    endfunction

    function longint axis_field(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
                                logic [FACT_W-1:0] sens);
      logic [WORD_W-1:0] w;
      longint            q;
      w = {hi, lo};
      if (res_mode == RES_MODE_HALF) begin
        w = w - HALF_SCALE_OFS;
      end else if (res_mode == RES_MODE_QUARTER) begin
        w = w - QUARTER_SCALE_OFS;
      end
      q = longint'($signed(w)) * gain_of(gain) / GAIN_DIVISOR;
      q = q * longint'(sens) * (longint'(1) << res_mode);
      return q / FIELD_DIVISOR;
    endfunction

    function longint temp_field(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo);
      longint diff;
      longint div;
      diff = longint'({hi, lo}) - longint'(temp_ref);
      // a zero divisor counts as one
      div  = (temp_scale == '0) ? 1 : longint'(temp_scale);
      return longint'($signed(temp_ofs)) + diff * TEMP_FACTOR / div;
    endfunction

    // Track the frame position; predict a reading when the ninth byte lands.
    function void note_byte(logic [BYTE_W-1:0] b, logic start);
      reading_t r;
      longint   v;
      if (start) begin
        frame[0]  = b;
        frame_len = 1;
        return;
      end
      if (frame_len == 0) return;
      if (frame_len < FRAME_BYTES - 1) begin
        frame[frame_len] = b;
        frame_len++;
        return;
      end
      frame_len = 0;
      r.status  = frame[0];
      r.read_error = (frame[0] & err_mask) != '0;
      if (r.read_error) begin
        r.temp = '0;
        r.fx   = '0;
        r.fy   = '0;
        r.fz   = '0;
      end else begin
        v = temp_field(frame[1], frame[2]);
        r.temp = v[TEMP_W-1:0];
        v = axis_field(frame[3], frame[4], xy_sens);
        r.fx = v[FIELD_W-1:0];
        v = axis_field(frame[5], frame[6], xy_sens);
        r.fy = v[FIELD_W-1:0];
        v = axis_field(frame[7], b, z_sens);
        r.fz = v[FIELD_W-1:0];
      end
      readings_due.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (readings_due.size() == 0) begin
        $error("reading with status %0h arrived with none outstanding", got.status);
        failures++;
        return;
      end
      want = readings_due.pop_front();
      checked++;
      if (want.read_error) flagged++;
      if (got.read_error !== want.read_error) begin
        $error("read_error: expected %0d, actual %0d", want.read_error, got.read_error);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status_value: expected %0h, actual %0h", want.status, got.status);
        failures++;
      end
      if (got.temp !== want.temp) begin
        $error("temperature: expected %0d, actual %0d", $signed(want.temp), $signed(got.temp));
        failures++;
      end
      if (got.fx !== want.fx) begin
        $error("field_x: expected %0d, actual %0d", $signed(want.fx), $signed(got.fx));
        failures++;
      end
      if (got.fy !== want.fy) begin
        $error("field_y: expected %0d, actual %0d", $signed(want.fy), $signed(got.fy));
        failures++;
      end
      if (got.fz !== want.fz) begin
        $error("field_z: expected %0d, actual %0d", $signed(want.fz), $signed(got.fz));
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mftf_in_if  in_chan ();
  mftf_out_if out_chan ();
  mftf_cfg_if cfg_chan ();

  magnetometer_frame_to_field u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  field_scoreboard sb = new();

  int src_run = 0;
  int snk_run = 0;
  bit src_calm;
  bit snk_calm;
  bit hold_sink = 1'b0;
  int bytes_sent = 0;
  int settings_used = 1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Per-item wait, in runs that are either busy (random waits) or calm (no waits).
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic send_byte(logic [BYTE_W-1:0] b, logic start);
    int gap;
    gap = draw_wait(src_run, src_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.data_byte   <= b;
    in_chan.frame_start <= start;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_byte(b, start);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [BYTE_W-1:0] status, int data_bytes);
    send_byte(status, 1'b1);
    repeat (data_bytes) send_byte(pick_byte(), 1'b0);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] data;
    case (idx)
      CFG_GAIN:                  mask = 16'h0007;
      CFG_RES_MODE:              mask = 16'h0003;
      CFG_TEMP_OFS:              mask = 16'h07FF;
      CFG_TEMP_REF:              mask = 16'hFFFF;
      CFG_ERR_MASK:              mask = 16'h00FF;
      default:                   mask = 16'h03FF;
    endcase
    data = CFG_DATA_W'(value) & mask;
    // unused upper bits must be ignored
    if ($urandom_range(0, 1) == 1) data = data | (CFG_DATA_W'($urandom) & ~mask);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_settings(int gain, int mode, int xy, int z, int tofs, int scale,
                                int ref_raw, int err);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_RES_MODE, mode);
    write_reg(CFG_XY_SENS, xy);
    write_reg(CFG_Z_SENS, z);
    write_reg(CFG_TEMP_OFS, tofs);
    write_reg(CFG_TEMP_SCALE, scale);
    write_reg(CFG_TEMP_REF, ref_raw);
    write_reg(CFG_ERR_MASK, err);
    cfg_chan.valid <= 1'b0;
    settings_used++;
  endtask

  // Hold until every reading is back, then let the sequencer go quiet.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_frames(int budget);
    int                sent;
    int                pick;
    int                n;
    logic [BYTE_W-1:0] status;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        status = BYTE_W'($urandom);
        if ($urandom_range(0, 2) != 0) status = status & ~sb.err_mask;
        send_frame(status, FRAME_BYTES - 1);
        sent += FRAME_BYTES;
        // now and then stop sending until the block has drained
        if ($urandom_range(0, 24) == 0) begin
          in_chan.valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
      end else if (pick < 90) begin
        n = $urandom_range(0, FRAME_BYTES - 1);
        send_frame(BYTE_W'($urandom), n);
        sent += n + 1;
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(pick_byte(), 1'b0);
      end
    end
  endtask

  task automatic random_settings();
    int scale;
    int err;
    scale = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(100, 1023);
    case ($urandom_range(0, 2))
      0:       err = 0;
      1:       err = int'(ERR_MASK_RST);
      default: err = $urandom_range(0, 255);
    endcase
    apply_settings($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 2047), scale,
                   $urandom_range(0, 65535), err);
  endtask

  initial begin
    int i;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.data_byte    <= '0;
    in_chan.frame_start  <= 1'b0;
    out_chan.ready       <= 1'b0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.index       <= CFG_GAIN;
    cfg_chan.data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray byte with no frame open, then a restart mid-frame
    send_byte(8'hA5, 1'b0);
    send_frame(8'h00, 2);
    send_byte(8'hEF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // error frame: status hits the default mask
    send_frame(8'hFF, FRAME_BYTES - 1);
    in_chan.valid <= 1'b0;
    settle();

    // largest gain, quarter-scale mode, zero divisor, most negative offset, no error bits
    apply_settings(0, RES_MODE_QUARTER, 1023, 1023, 11'h400, 0, 16'hFFFF, 0);
    run_frames(200);
    in_chan.valid <= 1'b0;
    settle();

    // smallest gain and sensitivities, divisor one, every status bit an error
    apply_settings(7, 0, 1, 1, 11'h3FF, 1, 0, 8'hFF);
    run_frames(200);
    in_chan.valid <= 1'b0;
    settle();

    apply_settings($urandom_range(0, 7), RES_MODE_HALF, $urandom_range(1, 1023),
                   $urandom_range(1, 1023), $urandom_range(0, 2047), $urandom_range(2, 99),
                   $urandom_range(0, 65535), 0);
    run_frames(200);
    in_chan.valid <= 1'b0;
    settle();

    for (i = 0; i < 4; i++) begin
      random_settings();
      // stall the result side long enough to back up the input
      if (i == 1) hold_sink = 1'b1;
      run_frames(200);
      in_chan.valid <= 1'b0;
      settle();
    end

    if (sb.pending() != 0) begin
      $error("%0d readings never arrived", sb.pending());
      sb.failures++;
    end
    $display("Sent %0d bytes under %0d register settings.", bytes_sent, settings_used);
    $display("Checked %0d readings, %0d of them read errors.", sb.checked, sb.flagged);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    reading_t got;
    int       stall;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = draw_wait(snk_run, snk_calm);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      got.read_error = out_chan.read_error;
      got.status     = out_chan.status_value;
      got.temp       = out_chan.temperature;
      got.fx         = out_chan.field_x;
      got.fy         = out_chan.field_y;
      got.fz         = out_chan.field_z;
      sb.check_reading(got);
    end
  end

  initial begin
    #(TIMEOUT);
    $display("Timed out with %0d readings outstanding.", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
